FILE: rtl/smf_pkg.sv
// Shared types and constants for the selection mask feather block.
`timescale 1ns / 1ps

package smf_pkg;

   localparam int CFG_BITS   = 9;
   localparam int COORD_BITS = 8;
   localparam int DIV_STEP   = 8;

   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_READ    = 3'd1;
   localparam logic [2:0] OP_INVERT  = 3'd2;
   localparam logic [2:0] OP_FILL    = 3'd3;
   localparam logic [2:0] OP_DROP    = 3'd4;
   localparam logic [2:0] OP_FEATHER = 3'd5;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_POKE,
      ST_PEEK,
      ST_PEEK_DATA,
      ST_FSELF,
      ST_FRIGHT,
      ST_FUP,
      ST_FDOWN,
      ST_FLAST,
      ST_FDIV,
      ST_FWRITE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SW_CLEAR,
      SW_FILL,
      SW_INVERT
   } sweep_type;

endpackage

FILE: rtl/selection_mask_feather.sv
// Top level of the selection mask feather block: frame store, sequencer and register port.
// A write goes through ST_POKE, a read through ST_PEEK and ST_PEEK_DATA, then ST_FINISH
// registers the response; a new request is taken only back in ST_IDLE. Invert and select
// all sweep the width by height grid; creating a mask first sweeps the whole store,
// MAX_ROWS*MAX_COLS words, with one store port each way. Feather handles each pixel in
// each pass with four single-port store reads followed by the iterative divider.
// Reset: grid 256 by 256, no mask present; store contents stay undefined and are not swept.
`timescale 1ns / 1ps

module selection_mask_feather
   import smf_pkg::*;
#(
   parameter int MAX_COLS   = 256,
   parameter int MAX_ROWS   = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0], col[10:3], row[18:11], pixel_in[34:19], passes[42:35], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_out[15:0], mask_present[16], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam int WD_BITS   = $clog2(MAX_COLS + 1);
   localparam int HT_BITS   = $clog2(MAX_ROWS + 1);
   localparam int CWW       = (WD_BITS > CFG_BITS) ? WD_BITS : CFG_BITS;
   localparam int CHW       = (HT_BITS > CFG_BITS) ? HT_BITS : CFG_BITS;
   localparam int CIW       = (WD_BITS > COORD_BITS) ? WD_BITS : COORD_BITS;
   localparam int RIW       = (HT_BITS > COORD_BITS) ? HT_BITS : COORD_BITS;
   localparam int SUM_BITS  = VALUE_BITS + 3;
   localparam logic [VALUE_BITS-1:0] FULL = '1;

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]   grid_width_ff, grid_width_in;
   logic [CFG_BITS-1:0]   grid_height_ff, grid_height_in;
   logic                  present_ff, present_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_present_ff, rsp_present_in;
   logic [2:0]            op_ff, op_in;
   logic                  inside_ff, inside_in;
   logic [ADDR_BITS-1:0]  at_ff, at_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [7:0]            pass_ff, pass_in;
   logic [15:0]           result_ff, result_in;
   logic [WD_BITS-1:0]    w_ff, w_in;
   logic [HT_BITS-1:0]    h_ff, h_in;
   logic [WD_BITS-1:0]    xlim_ff, xlim_in;
   logic [HT_BITS-1:0]    ylim_ff, ylim_in;
   logic [WD_BITS-1:0]    x_ff, x_in;
   logic [HT_BITS-1:0]    y_ff, y_in;
   sweep_type             mode_ff, mode_in;
   logic                  scan_run_ff, scan_run_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [ADDR_BITS-1:0]  s1_addr_ff, s1_addr_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [VALUE_BITS-1:0] left_ff, left_in;

   logic [VALUE_BITS-1:0] mask_store [DEPTH];
   logic [VALUE_BITS-1:0] mem_q_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr, mem_raddr;
   logic [VALUE_BITS-1:0] mem_wdata;

   logic [2:0]            f_op;
   logic [7:0]            f_col, f_row, f_passes;
   logic [15:0]           f_pixel;
   logic [CWW-1:0]        wcfg, wclamp;
   logic [CHW-1:0]        hcfg, hclamp;
   logic [WD_BITS-1:0]    w_v;
   logic [HT_BITS-1:0]    h_v;
   logic                  accept, create_v, sweep_done_v, last_pixel_v, rsp_free_v;
   logic                  has_left, has_right, has_up, has_down;
   logic [WD_BITS-1:0]    xp_v;
   logic [HT_BITS-1:0]    yp_v, ym_v;
   logic [ADDR_BITS-1:0]  self_addr, right_addr, up_addr, down_addr;
   logic [2:0]            count_v;
   logic                  div_start, div_done;
   logic [SUM_BITS-1:0]   div_numer;
   logic [VALUE_BITS-1:0] div_quot;
   logic                  csr_write;

   assign f_op     = req_tdata[2:0];
   assign f_col    = req_tdata[10:3];
   assign f_row    = req_tdata[18:11];
   assign f_pixel  = req_tdata[34:19];
   assign f_passes = req_tdata[42:35];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_present_ff, rsp_pixel_ff};
   assign rsp_free_v = !rsp_valid_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         REG_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
      endcase
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_GRID_WIDTH:  grid_width_in  = csr_pwdata[CFG_BITS-1:0];
            REG_GRID_HEIGHT: grid_height_in = csr_pwdata[CFG_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      wcfg = CWW'(grid_width_ff);
      hcfg = CHW'(grid_height_ff);
      priority if (wcfg == '0) begin
         wclamp = CWW'(1);
      end else if (wcfg > CWW'(MAX_COLS)) begin
         wclamp = CWW'(MAX_COLS);
      end else begin
         wclamp = wcfg;
      end
      priority if (hcfg == '0) begin
         hclamp = CHW'(1);
      end else if (hcfg > CHW'(MAX_ROWS)) begin
         hclamp = CHW'(MAX_ROWS);
      end else begin
         hclamp = hcfg;
      end
      w_v = WD_BITS'(wclamp);
      h_v = HT_BITS'(hclamp);
   end

   assign create_v = !present_ff && (f_op == OP_WRITE || f_op == OP_INVERT || f_op == OP_FILL);
   assign sweep_done_v = !scan_run_ff && !s1_valid_ff;
   assign last_pixel_v = (x_ff == xlim_ff) && (y_ff == ylim_ff) && (pass_ff == 8'd1);

   assign xp_v       = WD_BITS'(x_ff + WD_BITS'(1));
   assign yp_v       = HT_BITS'(y_ff + HT_BITS'(1));
   assign ym_v       = HT_BITS'(y_ff - HT_BITS'(1));
   assign has_left   = (x_ff != '0);
   assign has_right  = (xp_v < w_ff);
   assign has_up     = (y_ff != '0);
   assign has_down   = (yp_v < h_ff);
   assign self_addr  = {y_ff[ROW_BITS-1:0], x_ff[COL_BITS-1:0]};
   assign right_addr = {y_ff[ROW_BITS-1:0], xp_v[COL_BITS-1:0]};
   assign up_addr    = {ym_v[ROW_BITS-1:0], x_ff[COL_BITS-1:0]};
   assign down_addr  = {yp_v[ROW_BITS-1:0], x_ff[COL_BITS-1:0]};
   assign count_v    = 3'd1 + 3'(has_left) + 3'(has_right) + 3'(has_up) + 3'(has_down);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (create_v) begin
                  state_in = ST_SWEEP;
               end else begin
                  unique case (f_op)
                     OP_WRITE:   state_in = ST_POKE;
                     OP_READ:    state_in = ST_PEEK;
                     OP_INVERT:  state_in = ST_SWEEP;
                     OP_FILL:    state_in = ST_SWEEP;
                     OP_FEATHER: state_in = (present_ff && f_passes != 8'd0) ? ST_FSELF
                                                                            : ST_FINISH;
                     default:    state_in = ST_FINISH;
                  endcase
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_done_v) begin
               if (mode_ff == SW_CLEAR && op_ff == OP_WRITE) begin
                  state_in = ST_POKE;
               end else if (mode_ff == SW_CLEAR) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_POKE:      state_in = ST_FINISH;
         ST_PEEK:      state_in = ST_PEEK_DATA;
         ST_PEEK_DATA: state_in = ST_FINISH;
         ST_FSELF:     state_in = ST_FRIGHT;
         ST_FRIGHT:    state_in = ST_FUP;
         ST_FUP:       state_in = ST_FDOWN;
         ST_FDOWN:     state_in = ST_FLAST;
         ST_FLAST:     state_in = ST_FDIV;
         ST_FDIV: begin
            if (div_done) begin
               state_in = ST_FWRITE;
            end
         end
         ST_FWRITE:    state_in = last_pixel_v ? ST_FINISH : ST_FSELF;
         ST_FINISH: begin
            if (rsp_free_v) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      present_in     = present_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_present_in = rsp_present_ff;
      op_in          = op_ff;
      inside_in      = inside_ff;
      at_in          = at_ff;
      val_in         = val_ff;
      pass_in        = pass_ff;
      result_in      = result_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      xlim_in        = xlim_ff;
      ylim_in        = ylim_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      mode_in        = mode_ff;
      scan_run_in    = scan_run_ff;
      s1_valid_in    = 1'b0;
      s1_addr_in     = s1_addr_ff;
      sum_in         = sum_ff;
      left_in        = left_ff;
      mem_we         = 1'b0;
      mem_waddr      = at_ff;
      mem_wdata      = val_ff;
      mem_raddr      = at_ff;
      div_start      = 1'b0;
      div_numer      = sum_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = f_op;
               inside_in   = (CIW'(f_col) < CIW'(w_v)) && (RIW'(f_row) < RIW'(h_v));
               at_in       = {ROW_BITS'(f_row), COL_BITS'(f_col)};
               val_in      = VALUE_BITS'(f_pixel);
               pass_in     = f_passes;
               result_in   = '0;
               w_in        = w_v;
               h_in        = h_v;
               x_in        = '0;
               y_in        = '0;
               xlim_in     = WD_BITS'(w_v - WD_BITS'(1));
               ylim_in     = HT_BITS'(h_v - HT_BITS'(1));
               scan_run_in = 1'b0;
               if (create_v) begin
                  present_in  = 1'b1;
                  mode_in     = SW_CLEAR;
                  xlim_in     = WD_BITS'(MAX_COLS - 1);
                  ylim_in     = HT_BITS'(MAX_ROWS - 1);
                  scan_run_in = 1'b1;
               end else if (f_op == OP_INVERT) begin
                  mode_in     = SW_INVERT;
                  scan_run_in = 1'b1;
               end else if (f_op == OP_FILL) begin
                  mode_in     = SW_FILL;
                  scan_run_in = 1'b1;
               end
               if (f_op == OP_DROP) begin
                  present_in = 1'b0;
               end
            end
         end
         ST_SWEEP: begin
            mem_raddr = self_addr;
            if (scan_run_ff) begin
               s1_valid_in = 1'b1;
               s1_addr_in  = self_addr;
               if (x_ff == xlim_ff) begin
                  x_in = '0;
                  if (y_ff == ylim_ff) begin
                     scan_run_in = 1'b0;
                  end else begin
                     y_in = yp_v;
                  end
               end else begin
                  x_in = xp_v;
               end
            end
            if (s1_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = s1_addr_ff;
               unique case (mode_ff)
                  SW_CLEAR:  mem_wdata = '0;
                  SW_FILL:   mem_wdata = FULL;
                  SW_INVERT: mem_wdata = FULL - mem_q_ff;
                  default:   mem_wdata = '0;
               endcase
            end
            if (sweep_done_v && mode_ff == SW_CLEAR && op_ff != OP_WRITE) begin
               mode_in     = (op_ff == OP_INVERT) ? SW_INVERT : SW_FILL;
               xlim_in     = WD_BITS'(w_ff - WD_BITS'(1));
               ylim_in     = HT_BITS'(h_ff - HT_BITS'(1));
               x_in        = '0;
               y_in        = '0;
               scan_run_in = 1'b1;
            end
         end
         ST_POKE: begin
            mem_we = inside_ff;
         end
         ST_PEEK: begin
            mem_raddr = at_ff;
         end
         ST_PEEK_DATA: begin
            result_in = (present_ff && inside_ff) ? 16'(mem_q_ff) : 16'd0;
         end
         ST_FSELF: begin
            mem_raddr = self_addr;
            sum_in    = has_left ? SUM_BITS'(left_ff) : '0;
         end
         ST_FRIGHT: begin
            mem_raddr = right_addr;
            sum_in    = SUM_BITS'(sum_ff + SUM_BITS'(mem_q_ff));
         end
         ST_FUP: begin
            mem_raddr = up_addr;
            if (has_right) begin
               sum_in = SUM_BITS'(sum_ff + SUM_BITS'(mem_q_ff));
            end
         end
         ST_FDOWN: begin
            mem_raddr = down_addr;
            if (has_up) begin
               sum_in = SUM_BITS'(sum_ff + SUM_BITS'(mem_q_ff));
            end
         end
         ST_FLAST: begin
            div_start = 1'b1;
            div_numer = has_down ? SUM_BITS'(sum_ff + SUM_BITS'(mem_q_ff)) : sum_ff;
         end
         ST_FDIV: begin
         end
         ST_FWRITE: begin
            mem_we    = 1'b1;
            mem_waddr = self_addr;
            mem_wdata = div_quot;
            left_in   = div_quot;
            if (x_ff == xlim_ff) begin
               x_in = '0;
               if (y_ff == ylim_ff) begin
                  y_in    = '0;
                  pass_in = pass_ff - 8'd1;
               end else begin
                  y_in = yp_v;
               end
            end else begin
               x_in = xp_v;
            end
         end
         ST_FINISH: begin
            if (rsp_free_v) begin
               rsp_valid_in   = 1'b1;
               rsp_pixel_in   = result_ff;
               rsp_present_in = present_ff;
            end
         end
         default: begin
         end
      endcase
   end

   smf_div #(
      .NUM_BITS (SUM_BITS),
      .QUO_BITS (VALUE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (count_v),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mask_store[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mask_store[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= CFG_BITS'(256);
         grid_height_ff <= CFG_BITS'(256);
         present_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         scan_run_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         present_ff     <= present_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_run_ff    <= scan_run_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_present_ff <= rsp_present_in;
      op_ff          <= op_in;
      inside_ff      <= inside_in;
      at_ff          <= at_in;
      val_ff         <= val_in;
      pass_ff        <= pass_in;
      result_ff      <= result_in;
      w_ff           <= w_in;
      h_ff           <= h_in;
      xlim_ff        <= xlim_in;
      ylim_ff        <= ylim_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      mode_ff        <= mode_in;
      s1_addr_ff     <= s1_addr_in;
      sum_ff         <= sum_in;
      left_ff        <= left_in;
   end

endmodule

FILE: rtl/smf_div.sv
// Iterative divider of a pixel sum by a neighbour count of one to five.
`timescale 1ns / 1ps

module smf_div
   import smf_pkg::*;
#(
   parameter int NUM_BITS = 19,
   parameter int QUO_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [2:0]          denom,
   output logic                done,
   output logic [QUO_BITS-1:0] quot
);

   localparam int CYCLES   = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int PAD      = CYCLES * DIV_STEP;
   localparam int CNT_BITS = (CYCLES > 1) ? $clog2(CYCLES) : 1;

   logic               busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PAD-1:0]     num_ff, num_in;
   logic [PAD-1:0]     quo_ff, quo_in;
   logic [2:0]         rem_ff, rem_in;
   logic [2:0]         den_ff, den_in;
   logic [PAD-1:0]     num_v, quo_v;
   logic [2:0]         rem_v;

   always_comb begin
      logic [3:0] part_v;
      logic       bit_v;
      num_v = num_ff;
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         part_v = {rem_v, num_v[PAD-1]};
         if (part_v >= {1'b0, den_ff}) begin
            rem_v = 3'(part_v - {1'b0, den_ff});
            bit_v = 1'b1;
         end else begin
            rem_v = part_v[2:0];
            bit_v = 1'b0;
         end
         num_v = {num_v[PAD-2:0], 1'b0};
         quo_v = {quo_v[PAD-2:0], bit_v};
      end
   end

   assign done = busy_ff && (cnt_ff == CNT_BITS'(CYCLES - 1));
   assign quot = quo_ff[QUO_BITS-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = PAD'(numer);
         quo_in  = '0;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         num_in = num_v;
         quo_in = quo_v;
         rem_in = rem_v;
         cnt_in = CNT_BITS'(cnt_ff + CNT_BITS'(1));
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

FILE: rtl/smf_checker.sv
// Port-level assertions for the selection mask feather block and their bind.
`timescale 1ns / 1ps

module smf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result item dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("Result item changed while stalled.");

   a_no_mask_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[15:0] == 16'd0)
      else $error("Pixel data returned without a mask present.");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      !reset && csr_psel && csr_penable && csr_pwrite && csr_pready
      |=> (csr_paddr[2] != $past(csr_paddr[2])) ||
          (csr_prdata == {23'd0, $past(csr_pwdata[8:0])}))
      else $error("Register readback differs from the value written.");

endmodule

bind selection_mask_feather smf_checker u_smf_checker (.*);

FILE: verif/tb_selection_mask_feather.sv
// Self-checking testbench for the selection mask feather block with directed tests and random stream traffic.
`timescale 1ns / 1ps

module tb_selection_mask_feather;
   import smf_pkg::*;

   localparam int GRID_MAX = 256;
   localparam int STORE_WORDS = GRID_MAX * GRID_MAX;
   localparam logic [15:0] FULL_SCALE = 16'hFFFF;
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;
   localparam logic [2:0] ADDR_GRID_WIDTH = {REG_GRID_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};
   localparam int QUIET_LIMIT = 500000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 106;

   typedef struct packed {
      logic [7:0]  passes;
      logic [15:0] pixel_in;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [2:0]  op;
   } mask_req_type;

   typedef struct packed {
      logic        mask_present;
      logic [15:0] pixel_out;
   } mask_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit [15:0]    mask_mem [0:STORE_WORDS-1];
   bit           mask_on = 1'b0;
   bit [8:0]     width_reg = 9'd256;
   bit [8:0]     height_reg = 9'd256;
   mask_rsp_type mask_results_q [$];
   int           err_count = 0;
   int unsigned  quiet_cycles = 0;
   bit           req_gap_on = 1'b1;
   bit           rsp_stall_on = 1'b1;

   selection_mask_feather i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_dim(bit [8:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return int'(v);
   endfunction

   function automatic void create_mask();
      if (!mask_on) begin
         for (int i = 0; i < STORE_WORDS; i++) mask_mem[i] = '0;
         mask_on = 1'b1;
      end
   endfunction

   function automatic mask_rsp_type apply_mask_op(mask_req_type r);
      mask_rsp_type res;
      int w;
      int h;
      int at;
      int sum;
      int n;
      bit in_grid;
      res = '0;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      in_grid = (r.col < w) && (r.row < h);
      at = r.row * GRID_MAX + r.col;
      case (r.op)
         OP_WRITE: begin
            create_mask();
            if (in_grid) mask_mem[at] = r.pixel_in;
         end
         OP_READ: begin
            if (mask_on && in_grid) res.pixel_out = mask_mem[at];
         end
         OP_INVERT: begin
            create_mask();
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++)
                  mask_mem[y * GRID_MAX + x] = FULL_SCALE - mask_mem[y * GRID_MAX + x];
         end
         OP_FILL: begin
            create_mask();
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++) mask_mem[y * GRID_MAX + x] = FULL_SCALE;
         end
         OP_DROP: begin
            mask_on = 1'b0;
         end
         OP_FEATHER: begin
            if (mask_on) begin
               for (int p = 0; p < r.passes; p++)
                  for (int y = 0; y < h; y++)
                     for (int x = 0; x < w; x++) begin
                        at = y * GRID_MAX + x;
                        sum = mask_mem[at];
                        n = 1;
                        if (x > 0) begin sum += mask_mem[at - 1]; n++; end
                        if (x + 1 < w) begin sum += mask_mem[at + 1]; n++; end
                        if (y > 0) begin sum += mask_mem[at - GRID_MAX]; n++; end
                        if (y + 1 < h) begin sum += mask_mem[at + GRID_MAX]; n++; end
                        mask_mem[at] = 16'(sum / n);
                     end
            end
         end
         default: ;
      endcase
      res.mask_present = mask_on;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic send_item(input logic [2:0] op, input int col, input int row,
                            input int pix, input int passes);
      mask_req_type item;
      int gap;
      item.op = op;
      item.col = col[7:0];
      item.row = row[7:0];
      item.pixel_in = pix[15:0];
      item.passes = passes[7:0];
      gap = req_gap_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {5'b0, item};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      mask_results_q.push_back(apply_mask_op(item));
   endtask

   task automatic drain_items();
      req_tvalid <= 1'b0;
      while (mask_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_paddr <= addr;
      csr_pwdata <= data;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_GRID_WIDTH) width_reg = data[8:0];
      else if (addr == ADDR_GRID_HEIGHT) height_reg = data[8:0];
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [31:0] w_word, input logic [31:0] h_word);
      drain_items();
      csr_write(ADDR_GRID_WIDTH, w_word);
      csr_write(ADDR_GRID_HEIGHT, h_word);
   endtask

   task automatic test_absent_mask();
      send_item(OP_READ, 0, 0, 16'hFFFF, 0);
      send_item(OP_FEATHER, 3, 3, 0, 255);
      send_item(OP_DROP, 0, 0, 0, 0);
      send_item(OP_UNUSED_A, 255, 255, 16'hFFFF, 255);
      send_item(OP_UNUSED_B, 255, 255, 16'hFFFF, 255);
   endtask

   task automatic test_full_frame();
      set_grid(32'd256, 32'd256);
      send_item(OP_FILL, 0, 0, 0, 0);
      send_item(OP_FEATHER, 0, 0, 0, 0);
      send_item(OP_READ, 255, 255, 0, 0);
      send_item(OP_WRITE, 255, 255, 16'h0000, 0);
      send_item(OP_READ, 255, 255, 0, 0);
   endtask

   task automatic test_clamped_grid();
      set_grid(32'hFFFF_FE00, 32'h0000_01FF);
      send_item(OP_INVERT, 0, 0, 0, 0);
      send_item(OP_WRITE, 0, 100, 16'h1234, 0);
      send_item(OP_WRITE, 200, 0, 16'hABCD, 0);
      send_item(OP_FEATHER, 0, 0, 0, 1);
      send_item(OP_READ, 0, 100, 0, 0);
      send_item(OP_READ, 1, 0, 0, 0);
   endtask

   task automatic test_feather_corner();
      set_grid(32'd2, 32'd2);
      send_item(OP_WRITE, 0, 0, 16'hFFFF, 0);
      send_item(OP_FEATHER, 0, 0, 0, 255);
      send_item(OP_READ, 0, 0, 0, 0);
      send_item(OP_READ, 1, 1, 0, 0);
   endtask

   task automatic test_recreate_mask();
      send_item(OP_DROP, 0, 0, 0, 0);
      send_item(OP_READ, 1, 0, 0, 0);
      send_item(OP_WRITE, 1, 1, 16'h8000, 0);
      send_item(OP_READ, 1, 0, 0, 0);
   endtask

   task automatic test_random_traffic();
      logic [31:0] w_word;
      logic [31:0] h_word;
      logic [2:0]  op;
      int          w;
      int          h;
      int          col;
      int          row;
      int          pix;
      int          passes;
      int          pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         w_word = $urandom();
         h_word = $urandom();
         case ($urandom_range(0, 5))
            4: begin
               w_word[8:0] = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(256, 511));
               h_word[8:0] = 9'($urandom_range(1, 2));
            end
            5: begin
               w_word[8:0] = 9'($urandom_range(1, 2));
               h_word[8:0] = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(256, 511));
            end
            default: begin
               w_word[8:0] = 9'($urandom_range(1, 8));
               h_word[8:0] = 9'($urandom_range(1, 8));
            end
         endcase
         set_grid(w_word, h_word);
         pick = $urandom_range(0, 3);
         req_gap_on = pick[0];
         rsp_stall_on = pick[1];
         w = eff_dim(width_reg);
         h = eff_dim(height_reg);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 399);
            if (pick < 140) op = OP_WRITE;
            else if (pick < 280) op = OP_READ;
            else if (pick < 305) op = OP_INVERT;
            else if (pick < 315) op = OP_FILL;
            else if (pick < 385) op = OP_FEATHER;
            else if (pick < 387) op = OP_DROP;
            else op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
            if ($urandom_range(0, 4) != 0) begin
               col = $urandom_range(0, w - 1);
               row = $urandom_range(0, h - 1);
            end else begin
               col = $urandom_range(0, 255);
               row = $urandom_range(0, 255);
            end
            case ($urandom_range(0, 3))
               0: pix = 0;
               1: pix = 16'hFFFF;
               default: pix = $urandom_range(0, 65535);
            endcase
            if (w * h <= 4 && $urandom_range(0, 9) == 0) passes = $urandom_range(0, 255);
            else if (w * h > 64) passes = $urandom_range(0, 1);
            else passes = $urandom_range(0, 3);
            send_item(op, col, row, pix, passes);
         end
      end
   endtask

   always @(posedge clock) begin
      mask_rsp_type got;
      mask_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[16:0];
         if (mask_results_q.size() == 0) begin
            report_mismatch($sformatf("item with nothing awaited: %h", got));
         end else begin
            want = mask_results_q.pop_front();
            if (got.pixel_out !== want.pixel_out)
               report_mismatch($sformatf("pixel_out %h, awaited %h",
                                         got.pixel_out, want.pixel_out));
            if (got.mask_present !== want.mask_present)
               report_mismatch($sformatf("mask_present %b, awaited %b",
                                         got.mask_present, want.mask_present));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[selection_mask_feather] ERROR");
         $finish;
      end
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_stall_on ? $urandom_range(0, 13) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_absent_mask();
      test_full_frame();
      test_clamped_grid();
      test_feather_corner();
      test_recreate_mask();
      test_random_traffic();
      drain_items();
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("[selection_mask_feather] OK");
      else
         $display("[selection_mask_feather] ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/smf_pkg.sv
rtl/smf_div.sv
rtl/selection_mask_feather.sv
rtl/smf_checker.sv
verif/tb_selection_mask_feather.sv
